[rtl/lgs_pkg.sv]
// Shared definitions for the toroidal life grid block: grid geometry,
// operation codes and row types.
// No dependencies.
package lgs_pkg;

   localparam int GRID_WIDTH  = 128;
   localparam int GRID_HEIGHT = 64;
   localparam int COL_W       = $clog2(GRID_WIDTH);
   localparam int ROW_W       = $clog2(GRID_HEIGHT);
   localparam int GEN_W       = 32;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_TOGGLE = 2'd1,
      OP_STEP   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef logic [GRID_WIDTH-1:0] grid_row_type;
   typedef logic [ROW_W-1:0]      row_addr_type;
   typedef logic [COL_W-1:0]      col_addr_type;

endpackage

[rtl/life_grid_generation_step.sv]
// Toroidal life grid: row-wide grid memory, per-row valid bits and the
// operation sequencer. Depends on lgs_pkg.
// Usage:
//   The req_ channel carries one operation per beat: write, toggle or read
//   one cell, or advance the whole grid by one generation. The rsp_ channel
//   returns one beat per operation: the addressed cell after the operation
//   (0 for a generation step) and the generation counter.
//   The grid is held one row per word in a single synchronous RAM. A cell
//   operation reads its row, modifies it and writes it back: rsp_valid rises
//   after the CELL and RESP states, and the next request is taken only then.
//   A generation step sweeps the rows through the RAM, one row per cycle,
//   keeping three old rows plus the saved old first row in registers; all
//   cells of a row are updated in parallel. rsp_valid rises after the
//   PRIME_UP and PRIME_MID states, the sweep over all GRID_HEIGHT rows and
//   the RESP state; the next request is taken once the block is idle again.
//   Reset empties the grid at once through per-row valid bits (a row not
//   yet written reads as all dead) and sets the generation counter to 1.
//   While rsp_stall is high the result beat holds; the block still takes one
//   further request and waits with its result until the output register frees.
module life_grid_generation_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lgs_pkg::op_type             req_operation,
   input  logic [lgs_pkg::COL_W-1:0]   req_column,
   input  logic [lgs_pkg::ROW_W-1:0]   req_row,
   input  logic                        req_cell_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_cell_out,
   output logic [lgs_pkg::GEN_W-1:0]   rsp_generation
);
   import lgs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL,
      ST_PRIME_UP,
      ST_PRIME_MID,
      ST_RUN,
      ST_RESP
   } state_type;

   grid_row_type grid_mem [GRID_HEIGHT];
   logic [GRID_HEIGHT-1:0] row_valid_ff;

   state_type    state_ff, state_in;
   op_type       op_ff;
   col_addr_type col_ff;
   logic         val_ff;
   row_addr_type row_ff;
   row_addr_type cnt_ff, cnt_in;
   grid_row_type up_ff, up_in;
   grid_row_type mid_ff, mid_in;
   grid_row_type first_ff, first_in;
   grid_row_type rd_data_ff;
   logic         rd_valid_ff;
   logic         pend_cell_ff, pend_cell_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_cell_ff, rsp_cell_in;
   logic [GEN_W-1:0] rsp_gen_ff, rsp_gen_in;

   row_addr_type rd_addr;
   logic         wr_en;
   row_addr_type wr_addr;
   grid_row_type wr_data;
   grid_row_type old_row;
   grid_row_type down_row;
   grid_row_type mod_row;
   logic         new_bit;
   logic         req_take;

   function automatic grid_row_type next_row(grid_row_type up, grid_row_type mid,
                                             grid_row_type dn);
      grid_row_type res;
      int           l;
      int           r;
      logic [3:0]   n;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         l = (c == 0) ? GRID_WIDTH - 1 : c - 1;
         r = (c == GRID_WIDTH - 1) ? 0 : c + 1;
         n = {3'b000, up[l]} + {3'b000, up[c]} + {3'b000, up[r]}
           + {3'b000, mid[l]} + {3'b000, mid[r]}
           + {3'b000, dn[l]} + {3'b000, dn[c]} + {3'b000, dn[r]};
         res[c] = (n == 4'd3) || ((n == 4'd2) && mid[c]);
      end
      return res;
   endfunction

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_out   = rsp_cell_ff;
   assign rsp_generation = rsp_gen_ff;

   assign old_row  = rd_valid_ff ? rd_data_ff : '0;
   assign down_row = (cnt_ff == row_addr_type'(GRID_HEIGHT - 1)) ? first_ff : old_row;

   always_comb begin
      mod_row = old_row;
      unique case (op_ff)
         OP_WRITE:  new_bit = val_ff;
         OP_TOGGLE: new_bit = !old_row[col_ff];
         OP_STEP:   new_bit = 1'b0;
         OP_READ:   new_bit = old_row[col_ff];
         default:   new_bit = old_row[col_ff];
      endcase
      mod_row[col_ff] = new_bit;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      first_in     = first_ff;
      pend_cell_in = pend_cell_ff;
      gen_in       = gen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_gen_in   = rsp_gen_ff;
      rd_addr      = req_row;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = mod_row;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_operation == OP_STEP) begin
               rd_addr = row_addr_type'(GRID_HEIGHT - 1);
            end
            if (req_take) begin
               state_in = (req_operation == OP_STEP) ? ST_PRIME_UP : ST_CELL;
            end
         end
         ST_CELL: begin
            wr_en        = 1'b1;
            wr_addr      = row_ff;
            wr_data      = mod_row;
            pend_cell_in = new_bit;
            state_in     = ST_RESP;
         end
         ST_PRIME_UP: begin
            up_in    = old_row;
            rd_addr  = '0;
            state_in = ST_PRIME_MID;
         end
         ST_PRIME_MID: begin
            mid_in   = old_row;
            first_in = old_row;
            rd_addr  = row_addr_type'(1);
            cnt_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = next_row(up_ff, mid_ff, down_row);
            up_in   = mid_ff;
            mid_in  = down_row;
            rd_addr = row_addr_type'(cnt_ff + row_addr_type'(2));
            cnt_in  = row_addr_type'(cnt_ff + row_addr_type'(1));
            if (cnt_ff == row_addr_type'(GRID_HEIGHT - 1)) begin
               gen_in       = gen_ff + GEN_W'(1);
               pend_cell_in = 1'b0;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = pend_cell_ff;
               rsp_gen_in   = gen_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= GEN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         op_ff  <= req_operation;
         col_ff <= req_column;
         row_ff <= req_row;
         val_ff <= req_cell_in;
      end
      cnt_ff       <= cnt_in;
      up_ff        <= up_in;
      mid_ff       <= mid_in;
      first_ff     <= first_in;
      pend_cell_ff <= pend_cell_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_gen_ff   <= rsp_gen_in;
   end

endmodule

[sim/testbench.sv]
// Self-checking bench for life_grid_generation_step: a queue-fed driver offers
// cell and generation operations, and a monitor checks every result beat.
// Depends on lgs_pkg and the block under test.
module testbench;
   import lgs_pkg::*;

   typedef struct {
      op_type       op;
      col_addr_type col;
      row_addr_type row;
      logic         cell_in;
      int           gap;
      bit           drain_first;
   } life_op_type;

   typedef struct {
      logic             cell_bit;
      logic [GEN_W-1:0] generation;
   } cell_report_type;

   localparam int HOLD_AT    = 40;
   localparam int HOLD_LEN   = 150;
   localparam int DRAIN_AT   = 80;
   localparam int RANDOM_OPS = 78;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   op_type       req_operation = OP_READ;
   col_addr_type req_column = '0;
   row_addr_type req_row = '0;
   logic         req_cell_in = 1'b0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic         rsp_cell_out;
   logic [GEN_W-1:0] rsp_generation;

   grid_row_type     life_cells [GRID_HEIGHT];
   logic [GEN_W-1:0] life_generation;

   life_op_type     pending_ops [$];
   cell_report_type expected_reports [$];
   life_op_type     held_op;
   bit           holding = 0;
   int           gap_left = 0;
   int           ops_accepted = 0;
   int           results_seen = 0;
   int           stall_left = 0;
   int           fail_count = 0;
   int           ops_queued = 0;

   life_grid_generation_step dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_cell_in    (req_cell_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_out   (rsp_cell_out),
      .rsp_generation (rsp_generation)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic advance_life;
      grid_row_type fresh [GRID_HEIGHT];
      int n;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         for (int c = 0; c < GRID_WIDTH; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     n += life_cells[(r + dr + GRID_HEIGHT) % GRID_HEIGHT]
                                    [(c + dc + GRID_WIDTH) % GRID_WIDTH];
                  end
               end
            end
            if (n == 3)
               fresh[r][c] = 1'b1;
            else if (n == 2)
               fresh[r][c] = life_cells[r][c];
            else
               fresh[r][c] = 1'b0;
         end
      end
      life_cells = fresh;
      life_generation = life_generation + 1'b1;
   endtask

   task automatic apply_life_op(input life_op_type it, output cell_report_type rep);
      int c;
      int r;
      c = int'(it.col) % GRID_WIDTH;
      r = int'(it.row) % GRID_HEIGHT;
      rep.cell_bit = 1'b0;
      case (it.op)
         OP_WRITE: begin
            life_cells[r][c] = it.cell_in;
            rep.cell_bit = it.cell_in;
         end
         OP_TOGGLE: begin
            life_cells[r][c] = ~life_cells[r][c];
            rep.cell_bit = life_cells[r][c];
         end
         OP_STEP: begin
            advance_life();
         end
         default: begin
            rep.cell_bit = life_cells[r][c];
         end
      endcase
      rep.generation = life_generation;
   endtask

   task automatic queue_op(input op_type op, input int col, input int row, input logic cell_in);
      life_op_type it;
      it.op = op;
      it.col = col_addr_type'(col);
      it.row = row_addr_type'(row);
      it.cell_in = cell_in;
      it.drain_first = (ops_queued == DRAIN_AT) || ($urandom_range(0, 15) == 0);
      if ((ops_queued >= HOLD_AT - 4 && ops_queued < HOLD_AT + 24) || (ops_queued / 12) % 3 == 1)
         it.gap = 0;
      else
         it.gap = $urandom_range(0, 18);
      pending_ops.push_back(it);
      ops_queued++;
   endtask

   always @(posedge clock) begin
      cell_report_type rep;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_life_op(held_op, rep);
            expected_reports.push_back(rep);
            ops_accepted++;
            holding = 0;
         end
         if (!holding && pending_ops.size() != 0 &&
             !(pending_ops[0].drain_first && ops_accepted != results_seen)) begin
            held_op = pending_ops.pop_front();
            holding = 1;
            gap_left = held_op.gap;
         end
         if (holding && gap_left == 0) begin
            req_valid     <= 1'b1;
            req_operation <= held_op.op;
            req_column    <= held_op.col;
            req_row       <= held_op.row;
            req_cell_in   <= held_op.cell_in;
         end else begin
            req_valid <= 1'b0;
            if (holding)
               gap_left--;
         end
      end
   end

   always @(posedge clock) begin
      cell_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_reports.size() == 0) begin
               $error("unexpected result beat: cell_out %0d, generation %0d",
                      rsp_cell_out, rsp_generation);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_cell_out !== want.cell_bit) begin
                  $error("cell_out: expected %0d, got %0d", want.cell_bit, rsp_cell_out);
                  fail_count++;
               end
               if (rsp_generation !== want.generation) begin
                  $error("generation: expected %0d, got %0d", want.generation, rsp_generation);
                  fail_count++;
               end
            end
            if (results_seen == HOLD_AT)
               stall_left = HOLD_LEN;
            else if ((results_seen / 16) % 3 == 0)
               stall_left = 0;
            else
               stall_left = $urandom_range(0, 18);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   initial begin
      int cc;
      int cr;
      int steps;
      for (int r = 0; r < GRID_HEIGHT; r++)
         life_cells[r] = '0;
      life_generation = 1;

      // corners, block across the wrap, blinker across the side edge
      queue_op(OP_READ, 0, 0, 1'b1);
      queue_op(OP_READ, 127, 63, 1'b0);
      queue_op(OP_WRITE, 127, 63, 1'b1);
      queue_op(OP_WRITE, 0, 0, 1'b1);
      queue_op(OP_WRITE, 127, 0, 1'b1);
      queue_op(OP_STEP, 127, 63, 1'b1);
      queue_op(OP_READ, 0, 63, 1'b0);
      queue_op(OP_TOGGLE, 0, 63, 1'b1);
      queue_op(OP_READ, 0, 63, 1'b1);
      queue_op(OP_TOGGLE, 0, 63, 1'b0);
      queue_op(OP_WRITE, 127, 0, 1'b0);
      queue_op(OP_WRITE, 127, 0, 1'b1);
      queue_op(OP_WRITE, 126, 10, 1'b1);
      queue_op(OP_WRITE, 127, 10, 1'b1);
      queue_op(OP_TOGGLE, 0, 10, 1'b0);
      queue_op(OP_STEP, 0, 0, 1'b0);
      queue_op(OP_READ, 127, 9, 1'b1);
      queue_op(OP_READ, 127, 11, 1'b0);
      queue_op(OP_READ, 126, 10, 1'b1);
      queue_op(OP_STEP, 85, 42, 1'b1);
      queue_op(OP_READ, 0, 10, 1'b0);
      queue_op(OP_WRITE, 85, 42, 1'b0);

      while (ops_queued < 22 + RANDOM_OPS) begin
         if ($urandom_range(0, 9) < 2) begin
            queue_op(op_type'($urandom_range(0, 3)), $urandom_range(0, 127),
                     $urandom_range(0, 63), 1'($urandom_range(0, 1)));
         end else begin
            cc = $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 4)) - 2
                                           : int'($urandom_range(0, 127));
            cr = $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 4)) - 2
                                           : int'($urandom_range(0, 63));
            repeat ($urandom_range(3, 7)) begin
               queue_op($urandom_range(0, 4) == 0 ? OP_TOGGLE : OP_WRITE,
                        cc + $urandom_range(0, 4) - 2, cr + $urandom_range(0, 4) - 2,
                        1'($urandom_range(0, 5) != 0));
            end
            steps = $urandom_range(1, 3);
            repeat (steps) begin
               queue_op(OP_STEP, $urandom_range(0, 127), $urandom_range(0, 63),
                        1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(2, 5)) begin
               queue_op(OP_READ, cc + $urandom_range(0, 6) - 3, cr + $urandom_range(0, 6) - 3,
                        1'($urandom_range(0, 1)));
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || holding)
         @(posedge clock);
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (GRID_HEIGHT + 10) @(posedge clock);

      if (expected_reports.size() != 0) begin
         $error("results missing: %0d", expected_reports.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/lgs_pkg.sv
rtl/life_grid_generation_step.sv
sim/testbench.sv
